### rtl/tplp_pkg.sv
// Shared types, constants and arithmetic helpers for the three-pole resonant lowpass.
// Used by the microcode ROM, the sequencer, the datapath and the top level.
// Depends on nothing else.
`default_nettype none

package tplp_pkg;

  // Widths of the fixed fields and of the internal arithmetic.
  localparam int SMP_W      = 16;
  localparam int OUT_W      = 19;
  localparam int CUT_W      = 17;
  localparam int RES_W      = 20;
  localparam int DATA_W     = 32;
  localparam int B_W        = 21;
  localparam int PROD_W     = DATA_W + B_W;
  localparam int ACC_W      = 56;
  localparam int R16_W      = ACC_W - 16;
  localparam int R17_W      = ACC_W - 17;
  localparam int SAT_IN_W   = R16_W + 1;
  localparam int PC_W       = 5;
  localparam int NREG       = 10;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 20;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESONANCE = 4'd1;

  // Register limits and reset values.
  localparam logic [CUT_W-1:0] CUTOFF_MAX = 17'd65536;
  localparam logic [CUT_W-1:0] CUTOFF_RST = 17'd32768;
  localparam logic [RES_W-1:0] RES_MAX    = 20'd524288;

  // Arithmetic constants: Q16 one, allpass coefficient, rounding scale, clip and output limits.
  localparam logic signed [B_W-1:0]    COEF_ONE   = 21'sd65536;
  localparam logic signed [B_W-1:0]    AP_COEF    = -21'sd65405;
  localparam logic signed [B_W-1:0]    COEF_256   = 21'sd256;
  localparam logic signed [DATA_W-1:0] CLIP_LIMIT = 32'sd29360128;
  localparam logic signed [R16_W-1:0]  OUT_MAX    = 40'sd262143;
  localparam logic signed [R16_W-1:0]  OUT_MIN    = -40'sd262144;

  // Last step of the program.
  localparam logic [PC_W-1:0] LAST_PC = 5'd31;

  // Working register file addresses.
  typedef enum logic [3:0] {
    R_S1I, R_S1O, R_S2I, R_S2O, R_S3I, R_S3O, R_AP1, R_AP2, R_V, R_X
  } reg_idx_t;

  // Multiplier operand A source.
  typedef enum logic [1:0] {
    A_REG, A_CLIP, A_SMP
  } asrc_t;

  // Multiplier operand B (coefficient) select.
  typedef enum logic [2:0] {
    B_GP1, B_G, B_F1, B_F2, B_AP, B_ONE, B_C256
  } bsel_t;

  // Accumulator operation on the registered product.
  typedef enum logic [1:0] {
    ACC_LOAD, ACC_ADD, ACC_SUB
  } aop_t;

  // Write-back source.
  typedef enum logic [2:0] {
    W_R16, W_R17, W_NR16, W_MOVE, W_OUT
  } wsrc_t;

  // Step advance condition.
  typedef enum logic [1:0] {
    COND_ALWAYS, COND_IN, COND_OUT
  } cond_t;

  // One microcode control word.
  typedef struct packed {
    logic                m_en;
    asrc_t               asrc;
    reg_idx_t            ra;
    bsel_t               bsel;
    aop_t                aop;
    logic                wen;
    reg_idx_t            wd;
    wsrc_t               wsrc;
    cond_t               cond;
    logic                jump;
    logic [PC_W-1:0]     target;
  } ctrl_word_t;

  // Control passed from the sequencer to the datapath for the current step.
  typedef struct packed {
    logic       go;
    logic       load_in;
    ctrl_word_t cw;
  } step_t;

  localparam ctrl_word_t CW_NOP = ctrl_word_t'('0);

  // Saturate a wide signed value to the signed 32-bit range.
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SAT_IN_W-1:0] v);
    logic signed [SAT_IN_W-1:0] hi;
    logic signed [SAT_IN_W-1:0] lo;
    hi = SAT_IN_W'(64'sh7FFF_FFFF);
    lo = -SAT_IN_W'(64'sh8000_0000);
    if (v > hi) begin
      return DATA_W'(hi);
    end else if (v < lo) begin
      return DATA_W'(lo);
    end
    return DATA_W'(v);
  endfunction

  // Saturate a rounded value to the output sample range.
  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [R16_W-1:0] v);
    if (v > OUT_MAX) begin
      return OUT_W'(OUT_MAX);
    end else if (v < OUT_MIN) begin
      return OUT_W'(OUT_MIN);
    end
    return OUT_W'(v);
  endfunction

endpackage

`default_nettype wire

### rtl/tplp_ucode_rom.sv
// Microcode ROM: the per-sample filter program, one control word per step.
// Depends on tplp_pkg for the control word layout and field codes.
`default_nettype none

module tplp_ucode_rom
  import tplp_pkg::*;
(
  input  wire logic [PC_W-1:0] pc,
  output ctrl_word_t           cw
);

  // A multiply step with no write-back.
  function automatic ctrl_word_t mul(input asrc_t s, input reg_idx_t r,
                                     input bsel_t b, input aop_t o);
    ctrl_word_t c;
    c      = CW_NOP;
    c.m_en = 1'b1;
    c.asrc = s;
    c.ra   = r;
    c.bsel = b;
    c.aop  = o;
    return c;
  endfunction

  // A write-back step; for a move, r names the source register.
  function automatic ctrl_word_t wr(input reg_idx_t d, input wsrc_t w, input reg_idx_t r);
    ctrl_word_t c;
    c      = CW_NOP;
    c.wen  = 1'b1;
    c.wd   = d;
    c.wsrc = w;
    c.ra   = r;
    return c;
  endfunction

  // A multiply issued alongside a write-back from the accumulator.
  function automatic ctrl_word_t mulwr(input asrc_t s, input reg_idx_t r, input bsel_t b,
                                       input aop_t o, input reg_idx_t d, input wsrc_t w);
    ctrl_word_t c;
    c      = mul(s, r, b, o);
    c.wen  = 1'b1;
    c.wd   = d;
    c.wsrc = w;
    return c;
  endfunction

  // The program. A write-back waits for its last product to pass prod and then acc.
  always_comb begin
    cw = CW_NOP;
    case (pc)
      // Wait for a sample request.
      5'd0: begin
        cw      = CW_NOP;
        cw.cond = COND_IN;
      end
      // Input scaling and resonance feedback.
      5'd1:  cw = mul(A_SMP, R_V, B_GP1, ACC_LOAD);
      5'd2:  cw = mul(A_REG, R_S3O, B_G, ACC_SUB);
      // First lowpass section.
      5'd3:  cw = mul(A_REG, R_S1I, B_F1, ACC_LOAD);
      5'd4:  cw = mulwr(A_REG, R_S1O, B_F2, ACC_SUB, R_V, W_R16);
      5'd5:  cw = mul(A_REG, R_V, B_F1, ACC_ADD);
      5'd6:  cw = wr(R_S1I, W_MOVE, R_V);
      // Second lowpass section.
      5'd7:  cw = mulwr(A_REG, R_S2I, B_F1, ACC_LOAD, R_S1O, W_R17);
      5'd8:  cw = mul(A_REG, R_S2O, B_F2, ACC_SUB);
      5'd9:  cw = mul(A_REG, R_S1O, B_F1, ACC_ADD);
      5'd10: cw = wr(R_S2I, W_MOVE, R_S1O);
      // Third lowpass section.
      5'd11: cw = mulwr(A_REG, R_S3I, B_F1, ACC_LOAD, R_S2O, W_R17);
      5'd12: cw = mul(A_REG, R_S3O, B_F2, ACC_SUB);
      5'd13: cw = mul(A_REG, R_S2O, B_F1, ACC_ADD);
      5'd14: cw = wr(R_S3I, W_MOVE, R_S2O);
      5'd15: cw = wr(R_S3O, W_R17, R_V);
      // First allpass: output into X, then the new memory.
      5'd16: cw = mul(A_REG, R_S3O, B_AP, ACC_LOAD);
      5'd17: cw = mul(A_REG, R_AP1, B_ONE, ACC_ADD);
      5'd18: cw = CW_NOP;
      5'd19: cw = wr(R_X, W_R16, R_V);
      5'd20: cw = mul(A_REG, R_X, B_AP, ACC_LOAD);
      5'd21: cw = mul(A_REG, R_S3O, B_ONE, ACC_SUB);
      // Second allpass on the clipped first output; its result goes to V.
      5'd22: cw = mul(A_CLIP, R_X, B_AP, ACC_LOAD);
      5'd23: cw = mulwr(A_REG, R_AP2, B_ONE, ACC_ADD, R_AP1, W_NR16);
      5'd24: cw = CW_NOP;
      5'd25: cw = wr(R_V, W_R16, R_V);
      5'd26: cw = mul(A_REG, R_V, B_AP, ACC_LOAD);
      5'd27: cw = mul(A_CLIP, R_X, B_ONE, ACC_SUB);
      // Output rounding to whole samples.
      5'd28: cw = mul(A_REG, R_V, B_C256, ACC_LOAD);
      5'd29: cw = wr(R_AP2, W_NR16, R_V);
      5'd30: cw = CW_NOP;
      5'd31: begin
        cw        = wr(R_V, W_OUT, R_V);
        cw.cond   = COND_OUT;
        cw.jump   = 1'b1;
        cw.target = '0;
      end
      default: cw = CW_NOP;
    endcase
  end

endmodule

`default_nettype wire

### rtl/tplp_sequencer.sv
// Step counter of the microcoded filter: advance conditions, jumps and the output flag.
// Depends on tplp_pkg for the control word and step types.
`default_nettype none

module tplp_sequencer
  import tplp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic       out_ready,
  input  wire ctrl_word_t cw,
  output logic [PC_W-1:0] pc,
  output step_t           step,
  output logic            in_ready,
  output logic            out_valid
);

  logic            cond_ok;
  logic [PC_W-1:0] pc_next;
  logic            out_load;

  // A step advances only when its condition holds; a stalled step has no effect.
  always_comb begin
    case (cw.cond)
      COND_ALWAYS: cond_ok = 1'b1;
      COND_IN:     cond_ok = in_valid;
      COND_OUT:    cond_ok = !out_valid || out_ready;
      default:     cond_ok = 1'b0;
    endcase
  end

  // Next step: jump target, the following word, or hold.
  always_comb begin
    if (cond_ok) begin
      pc_next = cw.jump ? cw.target : pc + PC_W'(1);
    end else begin
      pc_next = pc;
    end
  end

  assign in_ready     = (cw.cond == COND_IN);
  assign out_load     = cond_ok && cw.wen && (cw.wsrc == W_OUT);
  assign step.go      = cond_ok;
  assign step.load_in = cond_ok && (cw.cond == COND_IN);
  assign step.cw      = cw;

  // Step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= '0;
    end else begin
      pc <= pc_next;
    end
  end

  // Result flag: set by the final step, cleared when the result request is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

### rtl/tplp_datapath.sv
// Filter datapath: register file, one shared multiplier, accumulator and write-back.
// Depends on tplp_pkg for types, constants and the saturation helpers.
`default_nettype none

module tplp_datapath
  import tplp_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire step_t                   step,
  input  wire logic signed [SMP_W-1:0] sample_in,
  input  wire logic [CUT_W-1:0]        cutoff,
  input  wire logic [RES_W-1:0]        resonance,
  output logic signed [OUT_W-1:0]      sample_out
);

  logic signed [DATA_W-1:0] regs [NREG];
  logic signed [SMP_W-1:0]  smp;
  logic signed [DATA_W-1:0] a_reg;
  logic signed [DATA_W-1:0] a_clip;
  logic signed [DATA_W-1:0] a_op;
  logic signed [B_W-1:0]    b_op;
  logic signed [PROD_W-1:0] prod_full;
  logic signed [PROD_W-1:0] prod;
  aop_t                     prod_op;
  logic                     prod_vld;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  acc_h16;
  logic signed [ACC_W-1:0]  acc_h17;
  logic signed [R16_W-1:0]  r16;
  logic signed [R17_W-1:0]  r17;
  logic signed [DATA_W-1:0] wval;
  logic                     reg_wr;
  logic                     out_wr;

  // Sample capture on an accepted input request.
  always_ff @(posedge clk) begin
    if (step.load_in) begin
      smp <= sample_in;
    end
  end

  // Operand A: a register, the same register clipped, or the sample in 24.8 form.
  assign a_reg  = regs[step.cw.ra];
  assign a_clip = (a_reg > CLIP_LIMIT) ? CLIP_LIMIT :
                  (a_reg < -CLIP_LIMIT) ? -CLIP_LIMIT : a_reg;

  always_comb begin
    case (step.cw.asrc)
      A_REG:   a_op = a_reg;
      A_CLIP:  a_op = a_clip;
      A_SMP:   a_op = {{(DATA_W-SMP_W-8){smp[SMP_W-1]}}, smp, 8'h00};
      default: a_op = a_reg;
    endcase
  end

  // Operand B: coefficients derived from the configuration and fixed constants.
  always_comb begin
    case (step.cw.bsel)
      B_GP1:   b_op = $signed(B_W'(resonance)) + COEF_ONE;
      B_G:     b_op = $signed(B_W'(resonance));
      B_F1:    b_op = $signed(B_W'(cutoff)) + COEF_ONE;
      B_F2:    b_op = $signed(B_W'({cutoff, 1'b0}));
      B_AP:    b_op = AP_COEF;
      B_ONE:   b_op = COEF_ONE;
      B_C256:  b_op = COEF_256;
      default: b_op = COEF_ONE;
    endcase
  end

  assign prod_full = a_op * b_op;

  // Product register, then accumulate in the cycle after.
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
    end else begin
      prod_vld <= step.go && step.cw.m_en;
    end
  end

  always_ff @(posedge clk) begin
    if (step.go && step.cw.m_en) begin
      prod    <= prod_full;
      prod_op <= step.cw.aop;
    end
  end

  assign prod_ext = ACC_W'(prod);

  always_ff @(posedge clk) begin
    if (prod_vld) begin
      case (prod_op)
        ACC_LOAD: acc <= prod_ext;
        ACC_ADD:  acc <= acc + prod_ext;
        ACC_SUB:  acc <= acc - prod_ext;
        default:  acc <= prod_ext;
      endcase
    end
  end

  // Rounding to nearest with ties upward, by 2^16 or 2^17.
  assign acc_h16 = acc + ACC_W'(32768);
  assign acc_h17 = acc + ACC_W'(65536);
  assign r16     = $signed(acc_h16[ACC_W-1:16]);
  assign r17     = $signed(acc_h17[ACC_W-1:17]);

  // Write-back value selection.
  always_comb begin
    case (step.cw.wsrc)
      W_R16:   wval = sat32(SAT_IN_W'(r16));
      W_R17:   wval = sat32(SAT_IN_W'(r17));
      W_NR16:  wval = sat32(SAT_IN_W'(0) - SAT_IN_W'(r16));
      W_MOVE:  wval = a_op;
      default: wval = sat32(SAT_IN_W'(r16));
    endcase
  end

  assign reg_wr = step.go && step.cw.wen && (step.cw.wsrc != W_OUT);
  assign out_wr = step.go && step.cw.wen && (step.cw.wsrc == W_OUT);

  // Filter state and working registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NREG; i++) begin
        regs[i] <= '0;
      end
    end else if (reg_wr) begin
      regs[step.cw.wd] <= wval;
    end
  end

  // Output holding register.
  always_ff @(posedge clk) begin
    if (out_wr) begin
      sample_out <= sat_out(r16);
    end
  end

endmodule

`default_nettype wire

### rtl/three_pole_resonant_lowpass_unit.sv
// Top level of the three-pole resonant lowpass with allpass phase stages.
// Depends on tplp_pkg, tplp_ucode_rom, tplp_sequencer and tplp_datapath.
//
//   Channel   Signals                                   Direction  Carries
//   s_axis    s_axis_tvalid/tready/tdata[15:0]          in         sample_in
//   m_axis    m_axis_tvalid/tready/tdata[23:0]          out        sample_out
//   cfg       cfg_valid/ready/index[3:0]/data[19:0]     in         register writes
//
// Each sample runs a 32-word microprogram that sends every product through
// one shared 32x21 multiplier and a 56-bit accumulator. The result is registered
// as the last program step completes, and the next request is taken from the
// following cycle while the previous result still waits. A result left unread
// stalls the program only at its last step. Synchronous reset clears the filter
// state, the step counter and the result flag, and restores register defaults.
`default_nettype none

module three_pole_resonant_lowpass_unit
  import tplp_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [15:0] sample_in
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,   // [18:0] sample_out, [23:19] zero
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [CUT_W-1:0]        cutoff;
  logic [RES_W-1:0]        resonance;
  logic [PC_W-1:0]         pc;
  ctrl_word_t              cw;
  step_t                   step;
  logic signed [OUT_W-1:0] sample_out;

  // Configuration registers, clamped to their upper limits on write.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cutoff    <= CUTOFF_RST;
      resonance <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CUTOFF: begin
          cutoff <= (cfg_data[CUT_W-1:0] > CUTOFF_MAX) ? CUTOFF_MAX : cfg_data[CUT_W-1:0];
        end
        CFG_RESONANCE: begin
          resonance <= (cfg_data[RES_W-1:0] > RES_MAX) ? RES_MAX : cfg_data[RES_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Program store, step counter and datapath.
  tplp_ucode_rom u_rom (
    .pc (pc),
    .cw (cw)
  );

  tplp_sequencer u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .out_ready (m_axis_tready),
    .cw        (cw),
    .pc        (pc),
    .step      (step),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid)
  );

  tplp_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .sample_in  ($signed(s_axis_tdata[SMP_W-1:0])),
    .cutoff     (cutoff),
    .resonance  (resonance),
    .sample_out (sample_out)
  );

  assign m_axis_tdata = {{(OUT_TDATA_W-OUT_W){1'b0}}, sample_out};

`ifndef SYNTHESIS
  // An accepted sample request starts the program at its first working step.
  a_start: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> (pc == PC_W'(1)))
    else $error("program did not start after an input request");

  // A result appears only as the last step of the program completes.
  a_result: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> ($past(pc) == LAST_PC && pc == '0))
    else $error("result raised outside the last program step");

  // Input is taken only while the program waits at its first word.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> (pc == '0))
    else $error("input ready while the program is running");

  // Configuration registers stay within their ranges.
  a_cfg: assert property (@(posedge clk) disable iff (rst)
    (cutoff <= CUTOFF_MAX) && (resonance <= RES_MAX))
    else $error("configuration register out of range");
`endif

endmodule

`default_nettype wire
